// ===== hw/rtl/atbb_pkg.sv =====
package atbb_pkg;

    localparam int ALPHA_W    = 8;
    localparam int SIZE_REG_W = 13;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = FRAC_BITS + 1;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // Normalized 1.0 in unsigned 1.16
    localparam logic [COORD_W-1:0] ONE_FIXED = COORD_W'(1) << FRAC_BITS;

    // Register map, index = paddr / 4
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd2;

    localparam logic [ALPHA_W-1:0]    THRESHOLD_RESET = '0;
    localparam logic [SIZE_REG_W-1:0] WIDTH_RESET     = 13'd1024;
    localparam logic [SIZE_REG_W-1:0] HEIGHT_RESET    = 13'd1024;

    // Per-pixel status from the position tracker
    typedef struct packed {
        logic frame_end;  // accepted pixel is the last one of the frame
        logic found;      // some pixel of the frame, this one included, qualified
    } atbb_frame_status_t;

endpackage

// ===== hw/rtl/alpha_threshold_bounding_box.sv =====
// Channel  | Dir | Transaction                   | Payload
// ---------+-----+-------------------------------+-----------------------------------------
// s_axis   | in  | s_tvalid & s_tready           | s_tdata[7:0] alpha
// m_axis   | out | m_tvalid & m_tready           | m_tuser found; m_tdata u_left, v_top,
//          |     |                               |   u_right, v_bottom (17 bits each)
// APB      | in  | psel & penable & pwrite       | 0x0 alpha_threshold, 0x4 frame_width,
//          |     |                               |   0x8 frame_height
//
// Cycles: one pixel per cycle inside a frame. The last pixel of a frame starts the
// end-of-frame work: when a pixel qualified, four serial divisions on the one shared
// restoring divider (each ST_START, then ST_WAIT until done), then a load of the output
// register; an empty frame goes straight to that load. s_tready is low until the load.
// Reset: rst_n clears counters, sequencer and output valid; registers take reset values.
// Stalls: a result waits in the output register while the next frame streams in; a
// further result waits in the sequencer until the output register frees.
module alpha_threshold_bounding_box
    import atbb_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] alpha
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [71:0]           m_tdata,   // [16:0] u_left, [33:17] v_top,
                                             // [50:34] u_right, [67:51] v_bottom,
                                             // [71:68] zero
    output logic                  m_tuser,   // [0] found
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    // Division order
    localparam logic [1:0] DIV_U_LEFT   = 2'd0;
    localparam logic [1:0] DIV_V_TOP    = 2'd1;
    localparam logic [1:0] DIV_U_RIGHT  = 2'd2;
    localparam logic [1:0] DIV_V_BOTTOM = 2'd3;

    // ---------------------------------------------------------------- config
    logic [ALPHA_W-1:0]    threshold_reg;
    logic [SIZE_REG_W-1:0] frame_width_reg;
    logic [SIZE_REG_W-1:0] frame_height_reg;
    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_idx == REG_ALPHA_THRESHOLD) threshold_reg    <= pwdata[ALPHA_W-1:0];
            if (reg_idx == REG_FRAME_WIDTH)     frame_width_reg  <= pwdata[SIZE_REG_W-1:0];
            if (reg_idx == REG_FRAME_HEIGHT)    frame_height_reg <= pwdata[SIZE_REG_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ALPHA_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            REG_FRAME_WIDTH:     prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT:    prdata = APB_DATA_W'(frame_height_reg);
            default:             prdata = '0;
        endcase
    end

    // Effective sizes: zero counts as one, clamp above MAX_DIMENSION
    logic [DIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;

    always_comb
    begin
        if (frame_width_reg == '0)
            eff_width = DIM_W'(1);
        else if (32'(frame_width_reg) > MAX_DIMENSION)
            eff_width = DIM_W'(MAX_DIMENSION);
        else
            eff_width = DIM_W'(frame_width_reg);

        if (frame_height_reg == '0)
            eff_height = DIM_W'(1);
        else if (32'(frame_height_reg) > MAX_DIMENSION)
            eff_height = DIM_W'(MAX_DIMENSION);
        else
            eff_height = DIM_W'(frame_height_reg);
    end

    // ---------------------------------------------------------------- tracker
    logic [1:0]         state_reg, state_next;
    logic [1:0]         div_idx_reg, div_idx_next;
    logic               found_reg, found_next;
    logic               pix_accept;
    atbb_frame_status_t status;
    logic [CNT_W-1:0]   min_col, max_col, min_row, max_row;

    assign s_tready   = (state_reg == ST_IDLE);
    assign pix_accept = s_tvalid && s_tready;

    atbb_tracker #(
        .CNT_W (CNT_W),
        .DIM_W (DIM_W)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_accept (pix_accept),
        .alpha      (s_tdata[ALPHA_W-1:0]),
        .threshold  (threshold_reg),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .status     (status),
        .min_col    (min_col),
        .max_col    (max_col),
        .min_row    (min_row),
        .max_row    (max_row)
    );

    // ---------------------------------------------------------------- divider
    logic               div_start;
    logic               div_done;
    logic [DIM_W-1:0]   div_num;
    logic [DIM_W-1:0]   div_den;
    logic [COORD_W-1:0] div_q;
    logic [COORD_W-1:0] res_reg [4];

    assign div_start = (state_reg == ST_START);

    // Pick the operands of the current division; extents stay put while busy
    always_comb
    begin
        unique case (div_idx_reg)
            DIV_U_LEFT:
            begin
                div_num = DIM_W'(min_col);
                div_den = eff_width;
            end
            DIV_V_TOP:
            begin
                div_num = DIM_W'(min_row);
                div_den = eff_height;
            end
            DIV_U_RIGHT:
            begin
                div_num = DIM_W'(max_col) + DIM_W'(1);
                div_den = eff_width;
            end
            default:
            begin
                div_num = DIM_W'(max_row) + DIM_W'(1);
                div_den = eff_height;
            end
        endcase
    end

    atbb_divider #(
        .DIM_W (DIM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (div_done)
            res_reg[div_idx_reg] <= div_q;
    end

    // ---------------------------------------------------------------- sequencer
    logic out_free;
    logic out_load;

    assign out_free = !m_tvalid || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        div_idx_next = div_idx_reg;
        found_next   = found_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Latch the frame verdict, then run the divisions if needed
                if (pix_accept && status.frame_end)
                begin
                    found_next   = status.found;
                    div_idx_next = DIV_U_LEFT;
                    state_next   = status.found ? ST_START : ST_OUT;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (div_idx_reg == DIV_V_BOTTOM)
                        state_next = ST_OUT;
                    else
                    begin
                        div_idx_next = div_idx_reg + 2'd1;
                        state_next   = ST_START;
                    end
                end
            end
            default:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_idx_reg <= DIV_U_LEFT;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_idx_reg <= div_idx_next;
            found_reg   <= found_next;
        end
    end

    // ---------------------------------------------------------------- output
    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // Empty frame: drop the stale quotients and send zeros
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tuser_reg <= found_reg;
            if (found_reg)
                m_tdata_reg <= {4'b0, res_reg[DIV_V_BOTTOM], res_reg[DIV_U_RIGHT],
                                res_reg[DIV_V_TOP], res_reg[DIV_U_LEFT]};
            else
                m_tdata_reg <= '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------- checks
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside a wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_q <= ONE_FIXED))
        else $error("normalized coordinate above one");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("result issued without the sequencer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("empty frame carries a box");

endmodule

// ===== hw/rtl/atbb_tracker.sv =====
module atbb_tracker
    import atbb_pkg::*;
#(
    parameter int CNT_W = 12,
    parameter int DIM_W = 13
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_accept,
    input  logic [ALPHA_W-1:0]  alpha,
    input  logic [ALPHA_W-1:0]  threshold,
    input  logic [DIM_W-1:0]    eff_width,
    input  logic [DIM_W-1:0]    eff_height,
    output atbb_frame_status_t  status,
    output logic [CNT_W-1:0]    min_col,
    output logic [CNT_W-1:0]    max_col,
    output logic [CNT_W-1:0]    min_row,
    output logic [CNT_W-1:0]    max_row
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic             any_found_reg, any_found_next;
    logic [CNT_W-1:0] min_col_reg, max_col_reg, min_row_reg, max_row_reg;
    logic             hit;
    logic             row_end;
    logic             frame_end;

    assign hit       = alpha < threshold;
    assign row_end   = (DIM_W'(col_reg) + DIM_W'(1)) >= eff_width;
    assign frame_end = row_end && ((DIM_W'(row_reg) + DIM_W'(1)) >= eff_height);

    assign status.frame_end = frame_end;
    assign status.found     = any_found_reg || hit;

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        any_found_next = any_found_reg;
        if (pix_accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
            any_found_next = frame_end ? 1'b0 : (any_found_reg || hit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            any_found_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            any_found_reg <= any_found_next;
        end
    end

    // Box extents: load on the first hit of a frame, widen afterwards
    always_ff @(posedge clk)
    begin
        if (pix_accept && hit)
        begin
            if (!any_found_reg)
            begin
                min_col_reg <= col_reg;
                max_col_reg <= col_reg;
                min_row_reg <= row_reg;
                max_row_reg <= row_reg;
            end
            else
            begin
                if (col_reg < min_col_reg) min_col_reg <= col_reg;
                if (col_reg > max_col_reg) max_col_reg <= col_reg;
                if (row_reg < min_row_reg) min_row_reg <= row_reg;
                if (row_reg > max_row_reg) max_row_reg <= row_reg;
            end
        end
    end

    assign min_col = min_col_reg;
    assign max_col = max_col_reg;
    assign min_row = min_row_reg;
    assign max_row = max_row_reg;

endmodule

// ===== hw/rtl/atbb_divider.sv =====
module atbb_divider
    import atbb_pkg::*;
#(
    parameter int DIM_W = 13
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIM_W-1:0]   num,
    input  logic [DIM_W-1:0]   den,
    output logic               done,
    output logic [COORD_W-1:0] quotient
);

    localparam int QW     = DIM_W + FRAC_BITS;
    localparam int STEP_W = $clog2(QW + 1);

    logic [QW-1:0]     dividend_reg;
    logic [DIM_W-1:0]  rem_reg;
    logic [DIM_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg;
    logic [DIM_W:0]    rem_sh;
    logic [DIM_W:0]    diff;
    logic              ge;
    logic              sat;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh = {rem_reg, dividend_reg[QW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        if (start)
            step_next = STEP_W'(QW);
        else if (step_reg != '0)
            step_next = step_reg - STEP_W'(1);
        else
            step_next = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= {num, FRAC_BITS'(0)};
            rem_reg      <= '0;
            den_reg      <= den;
        end
        else if (step_reg != '0)
        begin
            dividend_reg <= {dividend_reg[QW-2:0], ge};
            rem_reg      <= ge ? diff[DIM_W-1:0] : rem_sh[DIM_W-1:0];
        end
    end

    // Clamp to 1.0 when a size shrank mid-frame
    assign sat      = dividend_reg > QW'(ONE_FIXED);
    assign quotient = sat ? ONE_FIXED : dividend_reg[COORD_W-1:0];
    assign done     = done_reg;

endmodule
